FILE: src/bitmap_page_allocator_macros.svh
// ----------------------------------------------------------------------------
// bitmap page allocator assertion macros
// concurrent assertion wrappers clocked on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define BPA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared constants, codes and bitmap access types of the page allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bpa_pkg;

  // bitmap organization
  localparam int WORD_W         = 32;
  localparam int BIT_W          = 5;
  localparam int BMP_ADDR_W     = 6;
  localparam int PAGE_CAP       = 2047;
  localparam int DEF_MAX_PAGES  = 1024;
  localparam int DEF_WORDS      = 32;

  // field widths
  localparam int IDX_W          = 11;
  localparam int ADDR_W         = 64;

  // device address base
  localparam logic [63:0] DEVICE_BASE = 64'h0000_0001_0000_0000;

  // result status codes
  localparam logic [1:0] ST_ALLOCATED = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;
  localparam logic [1:0] ST_IGNORED   = 2'd3;

  // operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // configuration register indexes
  localparam logic CFG_PAGE_SHIFT = 1'b0;
  localparam logic CFG_PAGE_COUNT = 1'b1;

  // bitmap read and write requests
  typedef struct packed {
    logic                  en;
    logic [BMP_ADDR_W-1:0] addr;
  } bmp_rd_t;

  typedef struct packed {
    logic                  en;
    logic [BMP_ADDR_W-1:0] addr;
    logic [WORD_W-1:0]     data;
  } bmp_wr_t;

endpackage

FILE: src/bitmap_page_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// first-fit page allocator over a word-wise used bitmap in ram
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// in        request    in_valid / in_stall   operation, address
// out       result     out_valid / out_stall status, page_address, free_pages
// cfg       write      cfg_write             cfg_index, cfg_data
//
// a request is handled in the accept cycle, which picks the word (first non-full
// word for allocate, decoded page for free) and issues the ram read, and then
// in the modify step, which writes the changed word back on a grant and loads the result.
// the ram read is registered, so the modify step works on the word read in the accept cycle.
// reset clears the word valid bits at once, so no clearing pass is needed.
// a stalled result holds the modify step; the next request waits for it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int MAX_PAGES = DEF_MAX_PAGES
) (
  input  logic              clk,
  input  logic              rst,
  // configuration
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [10:0]       cfg_data,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              operation,
  input  logic [ADDR_W-1:0] address,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] page_address,
  output logic [IDX_W-1:0]  free_pages
);

  localparam int PAGE_LIMIT = (MAX_PAGES < PAGE_CAP) ? MAX_PAGES : PAGE_CAP;
  localparam int WORDS      = (PAGE_LIMIT + WORD_W - 1) / WORD_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_MOD  = 1'b1;

  logic             state;
  logic [4:0]       page_shift;
  logic [IDX_W-1:0] page_count;
  logic [IDX_W-1:0] pages_in_use;
  logic [IDX_W-1:0] eff_count;

  logic                  req_op;
  logic                  req_ok;
  logic [BMP_ADDR_W-1:0] req_word;
  logic [BIT_W-1:0]      req_bit;

  logic [IDX_W-1:0] out_index;

  bmp_rd_t           rd;
  bmp_wr_t           wr;
  logic [WORD_W-1:0] rdata;
  logic [WORDS-1:0]  full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= 5'd12;
      page_count <= 11'd1024;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PAGE_SHIFT: page_shift <= cfg_data[4:0];
        CFG_PAGE_COUNT: page_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign eff_count = (page_count > IDX_W'(PAGE_LIMIT)) ? IDX_W'(PAGE_LIMIT) : page_count;

  // first non-full word below the page count
  logic [6:0]            n_words;
  logic                  word_found;
  logic [BMP_ADDR_W-1:0] word_sel;

  assign n_words = 7'(({1'b0, eff_count} + 12'd31) >> 5);

  always_comb begin
    word_found = 1'b0;
    word_sel   = '0;
    for (int w = WORDS - 1; w >= 0; w--) begin
      if (!full[w] && (7'(w) < n_words)) begin
        word_found = 1'b1;
        word_sel   = BMP_ADDR_W'(w);
      end
    end
  end

  // free address decode
  logic [ADDR_W-1:0] addr_off;
  logic [ADDR_W-1:0] addr_idx;
  logic              free_ok;

  assign addr_off = {address[63:32] - 32'd1, address[31:0]};
  assign addr_idx = addr_off >> page_shift;
  assign free_ok  = (|address[63:32]) && (addr_idx[63:IDX_W] == '0) &&
                    (addr_idx[IDX_W-1:0] < eff_count);

  // handshake and control
  logic in_acc;
  logic mod_go;

  assign in_stall = (state == S_MOD);
  assign in_acc   = in_valid && !in_stall;
  assign mod_go   = (state == S_MOD) && !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (in_acc) state <= S_MOD;
        S_MOD:   if (mod_go) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_op   <= operation;
      req_ok   <= (operation == OP_ALLOC) ? word_found : free_ok;
      req_word <= (operation == OP_ALLOC) ? word_sel : addr_idx[IDX_W-1:BIT_W];
      req_bit  <= addr_idx[BIT_W-1:0];
    end
  end

  // ram read issued in the accept cycle
  always_comb begin
    rd.en   = in_acc;
    rd.addr = (operation == OP_ALLOC) ? word_sel : addr_idx[IDX_W-1:BIT_W];
  end

  // lowest free bit of the word read
  logic             has_zero;
  logic [BIT_W-1:0] zero_bit;

  always_comb begin
    has_zero = 1'b0;
    zero_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!rdata[b]) begin
        has_zero = 1'b1;
        zero_bit = BIT_W'(b);
      end
    end
  end

  // modify step
  logic [IDX_W-1:0]  alloc_idx;
  logic              grant;
  logic [WORD_W-1:0] word_new;
  logic [1:0]        status_next;

  assign alloc_idx = {req_word[IDX_W-BIT_W-1:0], zero_bit};

  always_comb begin
    if (req_op == OP_ALLOC) begin
      grant       = req_ok && has_zero && (alloc_idx < eff_count);
      word_new    = rdata | (WORD_W'(1) << zero_bit);
      status_next = grant ? ST_ALLOCATED : ST_FULL;
    end else begin
      grant       = req_ok && rdata[req_bit];
      word_new    = rdata & ~(WORD_W'(1) << req_bit);
      status_next = grant ? ST_FREED : ST_IGNORED;
    end
  end

  always_comb begin
    wr.en   = mod_go && grant;
    wr.addr = req_word;
    wr.data = word_new;
  end

  // pages in use
  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= '0;
    end else if (mod_go && grant) begin
      if (req_op == OP_ALLOC) begin
        pages_in_use <= pages_in_use + 11'd1;
      end else if (pages_in_use != '0) begin
        pages_in_use <= pages_in_use - 11'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mod_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mod_go) begin
      status    <= status_next;
      out_index <= alloc_idx;
    end
  end

  // address and free count from held result and current state
  assign page_address = (status == ST_ALLOCATED) ?
                        DEVICE_BASE + ({{(ADDR_W-IDX_W){1'b0}}, out_index} << page_shift) :
                        '0;
  assign free_pages   = (eff_count > pages_in_use) ? eff_count - pages_in_use : '0;

  bpa_bitmap #(
    .WORDS (WORDS)
  ) u_bitmap (
    .clk   (clk),
    .rst   (rst),
    .rd    (rd),
    .wr    (wr),
    .rdata (rdata),
    .full  (full)
  );

endmodule

FILE: src/bpa_bitmap.sv
// ----------------------------------------------------------------------------
// bpa_bitmap
// word-wide used-bit memory with per-word valid bits and a full summary
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bpa_bitmap
  import bpa_pkg::*;
#(
  parameter int WORDS = DEF_WORDS
) (
  input  logic              clk,
  input  logic              rst,
  input  bmp_rd_t           rd,
  input  bmp_wr_t           wr,
  output logic [WORD_W-1:0] rdata,
  output logic [WORDS-1:0]  full
);

  localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORDS-1:0]  valid;
  logic [WORD_W-1:0] rdata_q;
  logic              rvalid_q;

  // memory write port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[WA-1:0]] <= wr.data;
    end
  end

  // registered read, valid tag sampled with the data
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata_q <= mem[rd.addr[WA-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid_q <= 1'b0;
    end else if (rd.en) begin
      rvalid_q <= valid[rd.addr[WA-1:0]];
    end
  end

  // never-written words read as all free
  assign rdata = rvalid_q ? rdata_q : '0;

  // valid bits and full summary
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      full  <= '0;
    end else if (wr.en) begin
      valid[wr.addr[WA-1:0]] <= 1'b1;
      full[wr.addr[WA-1:0]]  <= &wr.data;
    end
  end

endmodule

FILE: src/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// port-level checks of the page allocator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bitmap_page_allocator_macros.svh"

module bpa_checker
  import bpa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cfg_write,
  input logic              cfg_index,
  input logic [10:0]       cfg_data,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        status,
  input logic [ADDR_W-1:0] page_address,
  input logic [IDX_W-1:0]  free_pages
);

  // page count as seen on the write port
  logic [10:0] cfg_count_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_count_q <= 11'd1024;
    end else if (cfg_write && (cfg_index == CFG_PAGE_COUNT)) begin
      cfg_count_q <= cfg_data;
    end
  end

  // only an allocation carries an address
  `BPA_ASSERT_IMPLY(a_no_addr, out_valid && status != ST_ALLOCATED, page_address == '0, "stray address")

  // allocated pages sit at or above the device base
  `BPA_ASSERT_IMPLY(a_base, out_valid && status == ST_ALLOCATED, page_address[63:32] != '0, "below base")

  // free count never exceeds the configured count
  `BPA_ASSERT_IMPLY(a_free_bound, out_valid, free_pages <= cfg_count_q, "free pages above count")

  // one request at a time
  `BPA_ASSERT_NEXT(a_one_req, in_valid && !in_stall, in_stall, "request taken while busy")

  // stalled result holds
  `BPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status), "result changed")

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);
